// File: sv/first_fit_page_allocator_defines.svh
// Assertion macros shared by the allocator RTL
`ifndef FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH

// Clocked check, held off while reset is high
`define FFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds through reset
`define FFPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/ffpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants and the page table entry type of the page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int NUM_PAGES = 1024;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = PAGE_W + 1;
  localparam int SUM_W     = CNT_W + 1;
  localparam int ENTRY_W   = CNT_W + 1;

  // One page table entry: free flag and block length (non-zero at heads)
  typedef struct packed {
    logic             free;
    logic [CNT_W-1:0] len;
  } entry_t;

endpackage

// File: sv/first_fit_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit page allocator with coalescing of adjacent free blocks.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  kind, page_index, page_count
// output   out        out_valid / out_stall ok, granted_page, free_count
//
// One request is worked on at a time against a single page table RAM.
// Allocate: reads each visited block head or reserved page, clears the n
// granted pages, and writes a new head when a remainder is split off.
// Free: checks the n pages, writes them free, looks at both neighbours, and
// walks down a lower free block page by page to merge into its head.
// After reset a clearing pass writes every table entry before the first transfer.
// A stalled result is held in the output register; the next request waits
// for its transfer before it can complete.
// ----------------------------------------------------------------------------
module first_fit_page_allocator
  import ffpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [PAGE_W-1:0] page_index,
  input  logic [CNT_W-1:0]  page_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [PAGE_W-1:0] granted_page,
  output logic [CNT_W-1:0]  free_count
);

  `include "first_fit_page_allocator_defines.svh"

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_A_RD   = 5'd2;
  localparam logic [4:0] S_A_EV   = 5'd3;
  localparam logic [4:0] S_A_CLR  = 5'd4;
  localparam logic [4:0] S_A_REM  = 5'd5;
  localparam logic [4:0] S_F_RD   = 5'd6;
  localparam logic [4:0] S_F_EV   = 5'd7;
  localparam logic [4:0] S_F_WR   = 5'd8;
  localparam logic [4:0] S_F_UP   = 5'd9;
  localparam logic [4:0] S_F_UPEV = 5'd10;
  localparam logic [4:0] S_F_DN   = 5'd11;
  localparam logic [4:0] S_F_DNEV = 5'd12;
  localparam logic [4:0] S_F_SOLO = 5'd13;
  localparam logic [4:0] S_F_WK   = 5'd14;
  localparam logic [4:0] S_F_WKEV = 5'd15;
  localparam logic [4:0] S_F_HRD  = 5'd16;
  localparam logic [4:0] S_F_HEV  = 5'd17;
  localparam logic [4:0] S_FIN    = 5'd18;

  logic [4:0]        state;
  logic              kind_r;
  logic [PAGE_W-1:0] idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  ptr;
  logic [PAGE_W-1:0] head;
  logic [CNT_W-1:0]  blen;
  logic [CNT_W-1:0]  tot;
  logic              r_ok;
  logic [PAGE_W-1:0] r_gp;
  logic [CNT_W-1:0]  free_total;

  logic              ram_we;
  logic [PAGE_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [PAGE_W-1:0] ram_raddr;
  entry_t            q;

  logic [SUM_W-1:0]  in_end;
  logic [SUM_W-1:0]  free_end;
  logic [SUM_W-1:0]  alloc_end;
  logic [SUM_W-1:0]  scan_next;
  logic [CNT_W-1:0]  step;

  ffpa_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_PAGES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (q)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_end    = {2'b0, page_index} + {1'b0, page_count};
  assign free_end  = {2'b0, idx_r} + {1'b0, cnt_r};
  assign alloc_end = {2'b0, head} + {1'b0, cnt_r};
  assign step      = (q.free && (q.len != '0)) ? q.len : CNT_W'(1);
  assign scan_next = {1'b0, ptr} + {1'b0, step};

  // Drive the table ports from the current step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[PAGE_W-1:0];
    ram_wdata = '0;
    ram_raddr = ptr[PAGE_W-1:0];
    unique case (state)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_A_CLR: begin
        ram_we = 1'b1;
      end
      S_A_REM: begin
        ram_we         = 1'b1;
        ram_waddr      = alloc_end[PAGE_W-1:0];
        ram_wdata.free = 1'b1;
        ram_wdata.len  = blen - cnt_r;
      end
      S_F_WR: begin
        ram_we         = 1'b1;
        ram_wdata.free = 1'b1;
      end
      S_F_UP: begin
        ram_raddr = free_end[PAGE_W-1:0];
      end
      S_F_UPEV: begin
        ram_we         = q.free;
        ram_waddr      = free_end[PAGE_W-1:0];
        ram_wdata.free = 1'b1;
      end
      S_F_DN: begin
        ram_raddr = idx_r - PAGE_W'(1);
      end
      S_F_DNEV: begin
        ram_we         = !q.free;
        ram_waddr      = idx_r;
        ram_wdata.free = 1'b1;
        ram_wdata.len  = tot;
      end
      S_F_SOLO: begin
        ram_we         = 1'b1;
        ram_waddr      = idx_r;
        ram_wdata.free = 1'b1;
        ram_wdata.len  = tot;
      end
      S_F_WK: begin
        ram_raddr = ptr[PAGE_W-1:0] - PAGE_W'(1);
      end
      S_F_HEV: begin
        ram_we         = 1'b1;
        ram_wdata.free = 1'b1;
        ram_wdata.len  = q.len + tot;
      end
      default: begin
      end
    endcase
  end

  // Sequence the request through read, modify and write-back steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      ptr        <= '0;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      // drop the result once it has been transferred
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          ptr <= ptr + CNT_W'(1);
          if (ptr == CNT_W'(NUM_PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= kind;
            idx_r  <= page_index;
            cnt_r  <= page_count;
            r_gp   <= '0;
            r_ok   <= 1'b0;
            if (!kind) begin
              ptr <= '0;
              if (page_count == '0 || page_count > free_total) begin
                state <= S_FIN;
              end else begin
                state <= S_A_RD;
              end
            end else begin
              ptr <= {1'b0, page_index};
              if (page_count == '0 || in_end > SUM_W'(NUM_PAGES)) begin
                state <= S_FIN;
              end else begin
                state <= S_F_RD;
              end
            end
          end
        end
        S_A_RD: begin
          state <= S_A_EV;
        end
        S_A_EV: begin
          if (q.free && q.len >= cnt_r) begin
            head  <= ptr[PAGE_W-1:0];
            blen  <= q.len;
            state <= S_A_CLR;
          end else if (scan_next >= SUM_W'(NUM_PAGES)) begin
            state <= S_FIN;
          end else begin
            ptr   <= scan_next[CNT_W-1:0];
            state <= S_A_RD;
          end
        end
        S_A_CLR: begin
          ptr <= ptr + CNT_W'(1);
          if ({1'b0, ptr} == alloc_end - SUM_W'(1)) begin
            if (blen > cnt_r && alloc_end < SUM_W'(NUM_PAGES)) begin
              state <= S_A_REM;
            end else begin
              free_total <= free_total - cnt_r;
              r_ok       <= 1'b1;
              r_gp       <= head;
              state      <= S_FIN;
            end
          end
        end
        S_A_REM: begin
          free_total <= free_total - cnt_r;
          r_ok       <= 1'b1;
          r_gp       <= head;
          state      <= S_FIN;
        end
        S_F_RD: begin
          state <= S_F_EV;
        end
        S_F_EV: begin
          if (q.free) begin
            state <= S_FIN;
          end else if ({1'b0, ptr} == free_end - SUM_W'(1)) begin
            ptr   <= {1'b0, idx_r};
            state <= S_F_WR;
          end else begin
            ptr   <= ptr + CNT_W'(1);
            state <= S_F_RD;
          end
        end
        S_F_WR: begin
          blen <= '0;
          if ({1'b0, ptr} == free_end - SUM_W'(1)) begin
            state <= S_F_UP;
          end else begin
            ptr <= ptr + CNT_W'(1);
          end
        end
        S_F_UP: begin
          if (free_end < SUM_W'(NUM_PAGES)) begin
            state <= S_F_UPEV;
          end else begin
            state <= S_F_DN;
          end
        end
        S_F_UPEV: begin
          if (q.free) begin
            blen <= q.len;
          end
          state <= S_F_DN;
        end
        S_F_DN: begin
          tot <= cnt_r + blen;
          if (idx_r == '0) begin
            state <= S_F_SOLO;
          end else begin
            state <= S_F_DNEV;
          end
        end
        S_F_DNEV: begin
          if (!q.free) begin
            free_total <= free_total + cnt_r;
            r_ok       <= 1'b1;
            state      <= S_FIN;
          end else begin
            ptr   <= {1'b0, idx_r} - CNT_W'(1);
            state <= S_F_WK;
          end
        end
        S_F_SOLO: begin
          free_total <= free_total + cnt_r;
          r_ok       <= 1'b1;
          state      <= S_FIN;
        end
        S_F_WK: begin
          if (ptr == '0) begin
            state <= S_F_HRD;
          end else begin
            state <= S_F_WKEV;
          end
        end
        S_F_WKEV: begin
          if (q.free) begin
            ptr   <= ptr - CNT_W'(1);
            state <= S_F_WK;
          end else begin
            state <= S_F_HRD;
          end
        end
        S_F_HRD: begin
          state <= S_F_HEV;
        end
        S_F_HEV: begin
          free_total <= free_total + cnt_r;
          r_ok       <= 1'b1;
          state      <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            ok           <= r_ok;
            granted_page <= kind_r ? '0 : r_gp;
            free_count   <= free_total;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFPA_ASSERT(a_total_in_pool, free_total <= CNT_W'(NUM_PAGES), "free count beyond pool")
  `FFPA_ASSERT(a_fail_no_page, out_valid && !ok |-> granted_page == '0, "granted page on failure")
  `FFPA_ASSERT(a_idle_no_write, state == S_IDLE |-> !ram_we, "table written while idle")
  `FFPA_ASSERT(a_fin_to_result, state == S_FIN && !(out_valid && out_stall) |=> out_valid,
               "result not presented")

endmodule

// File: sv/ffpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: dv/first_fit_page_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_tb
// Drives allocate and free requests into the page allocator and checks every
// result against a page-table predictor kept in the bench. It runs directed
// corner requests, then random traffic in several idle and stall phases.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_tb;
  import ffpa_pkg::*;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam int   STALL_LIMIT = 100000;

  typedef struct {
    logic             ok;
    logic [PAGE_W-1:0] granted;
    logic [CNT_W-1:0]  free_cnt;
  } alloc_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              kind;
  logic [PAGE_W-1:0] page_index;
  logic [CNT_W-1:0]  page_count;
  logic              out_valid;
  logic              out_stall;
  logic              ok;
  logic [PAGE_W-1:0] granted_page;
  logic [CNT_W-1:0]  free_count;

  // Predicted page table
  bit pg_free[NUM_PAGES];
  int run_len[NUM_PAGES];
  int pool_free;

  alloc_result_t expected_results[$];
  int held_base[$];
  int held_len[$];
  int fail_count;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  first_fit_page_allocator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .page_index(page_index), .page_count(page_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .granted_page(granted_page), .free_count(free_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Take the lowest fitting run, first fit by address
  function automatic bit pred_alloc(input int n, output int base);
    int i;
    int len;
    base = 0;
    if (n == 0 || n > pool_free) return 1'b0;
    i = 0;
    while (i < NUM_PAGES) begin
      if (pg_free[i]) begin
        len = run_len[i];
        if (len >= n) begin
          for (int k = 0; k < n && i + k < NUM_PAGES; k++) pg_free[i+k] = 1'b0;
          run_len[i] = 0;
          if (len > n && i + n < NUM_PAGES) run_len[i+n] = len - n;
          pool_free -= n;
          base = i;
          return 1'b1;
        end
        i += (len == 0) ? 1 : len;
      end else begin
        i++;
      end
    end
    return 1'b0;
  endfunction

  // Release a range and merge it with free neighbours
  function automatic bit pred_free(input int base, input int n);
    int head;
    if (n == 0 || base >= NUM_PAGES || n > NUM_PAGES - base) return 1'b0;
    for (int k = 0; k < n; k++)
      if (pg_free[base+k]) return 1'b0;
    for (int k = 0; k < n; k++) begin
      pg_free[base+k] = 1'b1;
      run_len[base+k] = 0;
    end
    run_len[base] = n;
    if (base + n < NUM_PAGES && pg_free[base+n]) begin
      run_len[base] += run_len[base+n];
      run_len[base+n] = 0;
    end
    if (base > 0 && pg_free[base-1]) begin
      head = base - 1;
      while (head > 0 && pg_free[head-1]) head--;
      run_len[head] += run_len[base];
      run_len[base] = 0;
    end
    pool_free += n;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  // Predict, then hold the transfer until it is taken
  task automatic send_request(input logic k, input int idx, input int cnt);
    alloc_result_t r;
    int base;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    base = 0;
    if (k == KIND_ALLOC) begin
      r.ok = pred_alloc(cnt % 2048, base);
      if (r.ok) begin
        held_base.push_back(base);
        held_len.push_back(cnt);
      end
    end else begin
      r.ok = pred_free(idx % 1024, cnt % 2048);
    end
    r.granted  = r.ok ? base[PAGE_W-1:0] : '0;
    r.free_cnt = pool_free[CNT_W-1:0];
    expected_results.push_back(r);
    in_valid   <= 1'b1;
    kind       <= k;
    page_index <= idx[PAGE_W-1:0];
    page_count <= cnt[CNT_W-1:0];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(KIND_ALLOC, 0, 1);        // empty pool
    send_request(KIND_FREE, 0, 0);         // zero count
    send_request(KIND_ALLOC, 0, 0);
    send_request(KIND_FREE, 1000, 100);    // past the pool
    send_request(KIND_FREE, 0, 2047);
    send_request(KIND_FREE, 1023, 1);      // last page
    send_request(KIND_FREE, 0, 1023);      // merges upward
    send_request(KIND_FREE, 5, 1);         // double free
    send_request(KIND_ALLOC, 0, 1024);     // whole pool
    send_request(KIND_ALLOC, 0, 1);        // nothing left
    send_request(KIND_FREE, 0, 1024);
    send_request(KIND_ALLOC, 0, 2047);     // more than free
    send_request(KIND_ALLOC, 1023, 100);
    send_request(KIND_ALLOC, 0, 100);
    send_request(KIND_ALLOC, 0, 50);
    send_request(KIND_FREE, 0, 100);       // below a held run
    send_request(KIND_ALLOC, 0, 200);      // no single run fits at the bottom
    send_request(KIND_FREE, 100, 50);      // merges downward
    send_request(KIND_ALLOC, 0, 1024);
    held_base.delete();
    held_len.delete();
    send_request(KIND_FREE, 512, 512);
    send_request(KIND_FREE, 0, 512);       // rejected, low pages already free
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 16);
    if (r < 95) return $urandom_range(17, 128);
    return $urandom_range(0, 2047);
  endfunction

  // Mostly alloc and release of held runs, some stray frees
  task automatic test_random_traffic(input int items, input int idle, input int stall);
    int r;
    int sel;
    int part;
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        send_request(KIND_ALLOC, $urandom_range(0, 1023), pick_count());
      end else if (r < 85 && held_base.size() != 0) begin
        sel  = $urandom_range(0, held_base.size() - 1);
        part = ($urandom_range(3) == 0) ? $urandom_range(1, held_len[sel]) : held_len[sel];
        send_request(KIND_FREE, held_base[sel], part);
        if (part == held_len[sel]) begin
          held_base.delete(sel);
          held_len.delete(sel);
        end else begin
          held_base[sel] += part;
          held_len[sel]  -= part;
        end
      end else begin
        send_request(KIND_FREE, $urandom_range(0, 1023), pick_count());
      end
    end
  endtask

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (ok !== e.ok) report_mismatch("ok", ok, e.ok);
        if (granted_page !== e.granted) report_mismatch("granted_page", granted_page, e.granted);
        if (free_count !== e.free_cnt) report_mismatch("free_count", free_count, e.free_cnt);
      end
    end
  end

  // Drive receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on transfer activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_ALLOC;
    page_index   = '0;
    page_count   = '0;
    out_stall    = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    quiet_cycles = 0;
    fail_count   = 0;
    pool_free    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(300, 0, 0);
    wait_drained();
    test_random_traffic(300, 49, 0);
    test_random_traffic(300, 0, 49);
    wait_drained();
    test_random_traffic(300, 15, 15);
    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
